// ===== sv/mcfe_pkg.sv =====
// shared types and constants of the mcu command frame engine
`timescale 1ns / 1ps
package mcfe_pkg;

  localparam int unsigned FRAME_BYTES = 12;
  localparam int unsigned BIDX_W = 4;
  localparam logic [BIDX_W-1:0] FRAME_LEN = 4'd12;
  localparam logic [BIDX_W-1:0] SEQ_POS = 4'd1;
  localparam logic [BIDX_W-1:0] SUM_POS = 4'd11;

  localparam logic [7:0] PAD_BYTE = 8'hFF;
  localparam logic [3:0] REJECT_NIBBLE = 4'hF;

  localparam logic [1:0] CMD_QUEUE = 2'd0;
  localparam logic [1:0] CMD_REPLY = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic KIND_TX = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [3:0] V_OK = 4'd0;
  localparam logic [3:0] V_UNSOLICITED = 4'd1;
  localparam logic [3:0] V_BAD_SUM = 4'd2;
  localparam logic [3:0] V_RETRY = 4'd3;
  localparam logic [3:0] V_REQUEUED = 4'd4;
  localparam logic [3:0] V_ABORTED = 4'd5;
  localparam logic [3:0] V_BAD_ID = 4'd6;
  localparam logic [3:0] V_BAD_SEQ = 4'd7;
  localparam logic [3:0] V_QUEUE_FULL = 4'd8;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGHEST_ID = 2'd1;
  localparam logic [2:0] RETRY_LIMIT_RST = 3'd3;
  localparam logic [7:0] HIGHEST_ID_RST = 8'd80;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take_in;
    logic store_byte;
    logic drop_cmd;
    logic pad_load;
    logic pad_step;
    logic seal_seq;
    logic seal_sum;
    logic reply_step;
    logic tick;
    logic idx_clear;
    logic idx_inc;
    logic grab_cid;
    logic grab_cseq;
    logic judge;
    logic emit_tx;
    logic emit_verdict;
  } ctl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [1:0] command;
    logic       last;
    logic       drop_needed;
    logic       reply_last;
    logic       pad_done;
    logic       send_done;
    logic       can_send;
    logic       empty;
    logic       full;
    logic       out_free;
  } dp_sts_t;

endpackage

// ===== sv/mcfe_datapath.sv =====
// datapath: frame store, queue pointers, reply collector, judge and output register
`timescale 1ns / 1ps
module mcfe_datapath #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mcfe_pkg::ctl_cmd_t                 cmd_i,
  output mcfe_pkg::dp_sts_t                  sts_o,
  input  logic [1:0]                         command_i,
  input  logic [7:0]                         data_byte_i,
  input  logic                               last_byte_i,
  input  logic                               cfg_valid_i,
  input  logic [mcfe_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [7:0]                         cfg_data_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic                               kind_o,
  output logic [7:0]                         tx_byte_o,
  output logic                               frame_end_o,
  output logic [3:0]                         verdict_o,
  output logic [7:0]                         reply_id_o,
  output logic                               start_timer_o
);
  import mcfe_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MEM_DEPTH = QUEUE_DEPTH * FRAME_BYTES;
  localparam int unsigned AW = $clog2(MEM_DEPTH);
  localparam logic [FW-1:0] FILL_MAX = FW'(QUEUE_DEPTH);
  localparam logic [FW:0] QD_EXT = (FW + 1)'(QUEUE_DEPTH);
  localparam logic [PW-1:0] HEAD_LAST = PW'(QUEUE_DEPTH - 1);

  logic [1:0]        cmd_q;
  logic [7:0]        byte_q;
  logic              last_q;
  logic [PW-1:0]     head_q;
  logic [FW-1:0]     fill_q;
  logic [BIDX_W-1:0] bidx_q;
  logic              blocked_q;
  logic [7:0]        bsum_q;
  logic [7:0]        seq_q;
  logic              pend_q;
  logic [BIDX_W-1:0] ridx_q;
  logic [7:0]        rsum_q;
  logic [7:0]        rid_q;
  logic [7:0]        rseq_q;
  logic [7:0]        rlast_q;
  logic [7:0]        cid_q;
  logic [7:0]        cseq_q;
  logic [BIDX_W-1:0] idx_q;
  logic [3:0]        verdict_q;
  logic              st_q;
  logic [2:0]        limit_q;
  logic [7:0]        hid_q;
  logic [7:0]        rd_q;
  logic [2:0]        rc_q;

  logic              out_valid_q;
  logic              kind_q;
  logic [7:0]        tx_q;
  logic              end_q;
  logic [3:0]        vout_q;
  logic [7:0]        id_out_q;
  logic              st_out_q;

  logic [7:0] frame_mem [MEM_DEPTH];
  logic [2:0] rc_mem [QUEUE_DEPTH];

  logic              full;
  logic              empty;
  logic              can_send;
  logic [FW:0]       tail_sum;
  logic [PW-1:0]     tail;
  logic [AW-1:0]     head_base;
  logic [AW-1:0]     tail_base;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [BIDX_W-1:0] wr_pos;
  logic [7:0]        wr_data;
  logic              wr_en;
  logic              store_ok;
  logic [7:0]        seq_next;
  logic [3:0]        cnt;
  logic [3:0]        j_verdict;
  logic              j_pop;
  logic              j_retry;
  logic              out_free;

  assign full = (fill_q == FILL_MAX);
  assign empty = (fill_q == '0);
  assign can_send = !empty && !pend_q;
  assign out_free = !out_valid_q || !out_stall_i;

  assign tail_sum = (FW + 1)'(head_q) + (FW + 1)'(fill_q);
  assign tail = (tail_sum >= QD_EXT) ? PW'(tail_sum - QD_EXT) : PW'(tail_sum);

  // slot * 12 as two shifts
  assign head_base = (AW'(head_q) << 3) + (AW'(head_q) << 2);
  assign tail_base = (AW'(tail) << 3) + (AW'(tail) << 2);
  assign rd_addr = head_base + AW'(idx_q);

  assign store_ok = cmd_i.store_byte && !full && (bidx_q < FRAME_LEN);
  assign seq_next = seq_q + 8'd1;
  assign wr_en = store_ok || cmd_i.pad_step || cmd_i.seal_seq || cmd_i.seal_sum;

  always_comb begin
    if (cmd_i.store_byte) begin
      wr_pos = bidx_q;
      wr_data = byte_q;
    end else if (cmd_i.pad_step) begin
      wr_pos = idx_q;
      wr_data = PAD_BYTE;
    end else if (cmd_i.seal_seq) begin
      wr_pos = SEQ_POS;
      wr_data = seq_next;
    end else begin
      wr_pos = SUM_POS;
      wr_data = bsum_q;
    end
  end
  assign wr_addr = tail_base + AW'(wr_pos);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= wr_data;
    end
    rd_q <= frame_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.seal_sum) begin
      rc_mem[tail] <= 3'd0;
    end else if (cmd_i.judge && j_retry) begin
      rc_mem[head_q] <= cnt[2:0];
    end
    rc_q <= rc_mem[head_q];
  end

  // reply judgement, in priority order
  assign cnt = {1'b0, rc_q} + 4'd1;
  always_comb begin
    j_pop = 1'b0;
    j_retry = 1'b0;
    if (empty) begin
      j_verdict = V_UNSOLICITED;
    end else if (rlast_q != rsum_q) begin
      j_verdict = V_BAD_SUM;
      j_pop = 1'b1;
    end else if (rid_q[7:4] == REJECT_NIBBLE) begin
      if (pend_q) begin
        j_verdict = V_REQUEUED;
      end else if (cnt > {1'b0, limit_q}) begin
        j_verdict = V_ABORTED;
        j_pop = 1'b1;
      end else begin
        j_verdict = V_RETRY;
        j_retry = 1'b1;
      end
    end else begin
      j_pop = 1'b1;
      if ((rid_q != cid_q) || (rid_q > hid_q)) begin
        j_verdict = V_BAD_ID;
      end else if (rseq_q != cseq_q) begin
        j_verdict = V_BAD_SEQ;
      end else begin
        j_verdict = V_OK;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
      bidx_q <= '0;
      blocked_q <= 1'b0;
      bsum_q <= '0;
      seq_q <= '0;
      pend_q <= 1'b0;
      ridx_q <= '0;
      rsum_q <= '0;
      idx_q <= '0;
      limit_q <= RETRY_LIMIT_RST;
      hid_q <= HIGHEST_ID_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_RETRY_LIMIT: limit_q <= cfg_data_i[2:0];
          REG_HIGHEST_ID:  hid_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.store_byte) begin
        if (full) begin
          blocked_q <= 1'b1;
        end
        if (bidx_q < FRAME_LEN) begin
          bidx_q <= bidx_q + 4'd1;
        end
        if (store_ok && (bidx_q != SEQ_POS) && (bidx_q < SUM_POS)) begin
          bsum_q <= bsum_q + byte_q;
        end
      end
      if (cmd_i.drop_cmd || cmd_i.seal_sum) begin
        bidx_q <= '0;
        blocked_q <= 1'b0;
        bsum_q <= '0;
      end
      if (cmd_i.pad_step && (idx_q != SEQ_POS)) begin
        bsum_q <= bsum_q + PAD_BYTE;
      end
      if (cmd_i.seal_seq) begin
        seq_q <= seq_next;
        bsum_q <= bsum_q + seq_next;
      end
      if (cmd_i.seal_sum) begin
        fill_q <= fill_q + FW'(1);
      end
      if (cmd_i.judge) begin
        rsum_q <= '0;
        if (j_pop) begin
          head_q <= (head_q == HEAD_LAST) ? '0 : head_q + PW'(1);
          fill_q <= fill_q - FW'(1);
        end
        if (j_retry) begin
          pend_q <= 1'b1;
        end
      end
      if (cmd_i.tick) begin
        pend_q <= 1'b0;
      end
      if (cmd_i.reply_step) begin
        if (ridx_q < SUM_POS) begin
          rsum_q <= rsum_q + byte_q;
        end
        ridx_q <= (ridx_q >= SUM_POS) ? '0 : ridx_q + 4'd1;
      end
      if (cmd_i.pad_load) begin
        idx_q <= bidx_q;
      end else if (cmd_i.idx_clear) begin
        idx_q <= '0;
      end else if (cmd_i.pad_step || cmd_i.idx_inc) begin
        idx_q <= idx_q + 4'd1;
      end
      if (cmd_i.emit_tx || cmd_i.emit_verdict || cmd_i.drop_cmd) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      cmd_q <= command_i;
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
    if (cmd_i.reply_step) begin
      if (ridx_q == '0) rid_q <= byte_q;
      if (ridx_q == SEQ_POS) rseq_q <= byte_q;
      if (ridx_q == SUM_POS) rlast_q <= byte_q;
    end
    if (cmd_i.grab_cid) cid_q <= rd_q;
    if (cmd_i.grab_cseq) cseq_q <= rd_q;
    if (cmd_i.judge) begin
      verdict_q <= j_verdict;
      st_q <= j_retry;
    end
    if (cmd_i.emit_tx) begin
      kind_q <= KIND_TX;
      tx_q <= rd_q;
      end_q <= (idx_q == SUM_POS);
      vout_q <= V_OK;
      id_out_q <= '0;
      st_out_q <= 1'b0;
    end else if (cmd_i.emit_verdict) begin
      kind_q <= KIND_VERDICT;
      tx_q <= '0;
      end_q <= !can_send;
      vout_q <= verdict_q;
      id_out_q <= rid_q;
      st_out_q <= st_q;
    end else if (cmd_i.drop_cmd) begin
      kind_q <= KIND_VERDICT;
      tx_q <= '0;
      end_q <= 1'b1;
      vout_q <= V_QUEUE_FULL;
      id_out_q <= '0;
      st_out_q <= 1'b0;
    end
  end

  assign sts_o.command = cmd_q;
  assign sts_o.last = last_q;
  assign sts_o.drop_needed = blocked_q || full;
  assign sts_o.reply_last = (ridx_q >= SUM_POS);
  assign sts_o.pad_done = (idx_q >= SUM_POS);
  assign sts_o.send_done = (idx_q == SUM_POS);
  assign sts_o.can_send = can_send;
  assign sts_o.empty = empty;
  assign sts_o.full = full;
  assign sts_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign kind_o = kind_q;
  assign tx_byte_o = tx_q;
  assign frame_end_o = end_q;
  assign verdict_o = vout_q;
  assign reply_id_o = id_out_q;
  assign start_timer_o = st_out_q;

endmodule

// ===== sv/mcfe_controller.sv =====
// controller state machine sequencing queue, seal, send and judge steps
`timescale 1ns / 1ps
module mcfe_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mcfe_pkg::dp_sts_t  sts_i,
  output mcfe_pkg::ctl_cmd_t cmd_o
);
  import mcfe_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_DROP     = 4'd2;
  localparam logic [3:0] S_PAD_INIT = 4'd3;
  localparam logic [3:0] S_PAD      = 4'd4;
  localparam logic [3:0] S_SEAL_SEQ = 4'd5;
  localparam logic [3:0] S_SEAL_SUM = 4'd6;
  localparam logic [3:0] S_SEND_CHK = 4'd7;
  localparam logic [3:0] S_SEND_RD  = 4'd8;
  localparam logic [3:0] S_SEND_OUT = 4'd9;
  localparam logic [3:0] S_JG_CLR   = 4'd10;
  localparam logic [3:0] S_JG_RD0   = 4'd11;
  localparam logic [3:0] S_JG_ID    = 4'd12;
  localparam logic [3:0] S_JG_SEQ   = 4'd13;
  localparam logic [3:0] S_JG_EVAL  = 4'd14;
  localparam logic [3:0] S_VERDICT  = 4'd15;

  logic [3:0] state_q;
  logic [3:0] state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.command)
          CMD_QUEUE: begin
            cmd_o.store_byte = 1'b1;
            if (!sts_i.last) begin
              state_d = S_IDLE;
            end else if (sts_i.drop_needed) begin
              state_d = S_DROP;
            end else begin
              state_d = S_PAD_INIT;
            end
          end
          CMD_REPLY: begin
            cmd_o.reply_step = 1'b1;
            state_d = sts_i.reply_last ? S_JG_CLR : S_IDLE;
          end
          CMD_TICK: begin
            cmd_o.tick = 1'b1;
            state_d = S_SEND_CHK;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_DROP: begin
        if (sts_i.out_free) begin
          cmd_o.drop_cmd = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_PAD_INIT: begin
        cmd_o.pad_load = 1'b1;
        state_d = S_PAD;
      end
      S_PAD: begin
        if (sts_i.pad_done) begin
          state_d = S_SEAL_SEQ;
        end else begin
          cmd_o.pad_step = 1'b1;
        end
      end
      S_SEAL_SEQ: begin
        cmd_o.seal_seq = 1'b1;
        state_d = S_SEAL_SUM;
      end
      S_SEAL_SUM: begin
        cmd_o.seal_sum = 1'b1;
        state_d = sts_i.empty ? S_SEND_CHK : S_IDLE;
      end
      S_SEND_CHK: begin
        if (sts_i.can_send) begin
          cmd_o.idx_clear = 1'b1;
          state_d = S_SEND_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SEND_RD: begin
        state_d = S_SEND_OUT;
      end
      S_SEND_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_tx = 1'b1;
          if (sts_i.send_done) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d = S_SEND_RD;
          end
        end
      end
      S_JG_CLR: begin
        cmd_o.idx_clear = 1'b1;
        state_d = S_JG_RD0;
      end
      S_JG_RD0: begin
        cmd_o.idx_inc = 1'b1;
        state_d = S_JG_ID;
      end
      S_JG_ID: begin
        cmd_o.grab_cid = 1'b1;
        state_d = S_JG_SEQ;
      end
      S_JG_SEQ: begin
        cmd_o.grab_cseq = 1'b1;
        state_d = S_JG_EVAL;
      end
      S_JG_EVAL: begin
        cmd_o.judge = 1'b1;
        state_d = S_VERDICT;
      end
      S_VERDICT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_verdict = 1'b1;
          state_d = S_SEND_CHK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/mcu_command_frame_engine_unit.sv =====
// top level of the mcu command frame engine
`timescale 1ns / 1ps
// host side of a 12-byte request/reply link to a power controller mcu.
// input channel (in_valid_i / in_stall_o) carries one item per byte event:
//   command 0 queues a command byte, 1 delivers a reply byte, 2 is a
//   recovery timer expiry; command 3 is swallowed without a result.
// output channel (out_valid_o / out_stall_i) carries transmit bytes
//   (kind 0, frame_end on the twelfth) and reply verdicts (kind 1).
// config channel (cfg_valid_i / cfg_ready_o, always ready): index 0 is
//   retry_limit, index 1 highest_reply_id; other indexes are dropped.
// one item at a time: a plain queued byte is stored and the sequencer goes
//   back to idle, the last byte of a command adds padding and sealing in the
//   frame memory, a reply judgement reads the queued id and seq before its
//   verdict; each sent frame byte is read through the single frame memory read port.
// results go through one output register; a stalled receiver holds the
//   sequencer where it is, nothing is lost.
// reset empties the queue, clears counters and the pending wait, and
//   loads the register defaults; the frame store needs no clearing.
module mcu_command_frame_engine_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     command_i,
  input  logic [7:0]                     data_byte_i,
  input  logic                           last_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           kind_o,
  output logic [7:0]                     tx_byte_o,
  output logic                           frame_end_o,
  output logic [3:0]                     verdict_o,
  output logic [7:0]                     reply_id_o,
  output logic                           start_timer_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mcfe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);
  import mcfe_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_sts_t  dp_sts;

  // registers take a write in any cycle
  assign cfg_ready_o = 1'b1;

  mcfe_controller u_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (ctl_cmd)
  );

  mcfe_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctl_cmd),
    .sts_o         (dp_sts),
    .command_i     (command_i),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .cfg_valid_i   (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .kind_o        (kind_o),
    .tx_byte_o     (tx_byte_o),
    .frame_end_o   (frame_end_o),
    .verdict_o     (verdict_o),
    .reply_id_o    (reply_id_o),
    .start_timer_o (start_timer_o)
  );

`ifndef SYNTHESIS
  // an accepted item holds off the next one: the input stalls in the cycle after acceptance
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted while previous one still in work");

  // verdict items never carry a transmit byte
  a_verdict_no_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KIND_VERDICT)) |-> (tx_byte_o == 8'd0))
    else $error("verdict item with nonzero tx byte");

  // timer start only comes with a retry verdict
  a_timer_retry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && start_timer_o) |-> ((kind_o == KIND_VERDICT) && (verdict_o == V_RETRY)))
    else $error("timer start without retry verdict");

  // queue never reads as both full and empty
  a_queue_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dp_sts.full && dp_sts.empty))
    else $error("queue fill flags inconsistent");
`endif

endmodule

// ===== tb/sv/mcu_command_frame_engine_unit_test.sv =====
// self-checking testbench of the mcu command frame engine
`timescale 1ns / 1ps
module mcu_command_frame_engine_unit_test;
  import mcfe_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  // one result item as the block shows it
  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic       frame_end;
    logic [3:0] verdict;
    logic [7:0] reply_id;
    logic       start_timer;
  } engine_result_t;

  // predictor of the engine with its own state, plus the store of expected results
  class frame_engine_scoreboard;
    logic [7:0] frames [DEPTH*FRAME_BYTES];
    logic [2:0] tries [DEPTH];
    int unsigned head, fill, build_idx, rx_idx;
    bit blocked, waiting;
    logic [7:0] seq_no, rx_sum;
    logic [7:0] rx_buf [FRAME_BYTES];
    logic [2:0] retry_limit;
    logic [7:0] highest_id;
    engine_result_t pending_results[$];
    int unsigned errors;

    function new();
      head = 0; fill = 0; build_idx = 0; rx_idx = 0;
      blocked = 0; waiting = 0; seq_no = 0; rx_sum = 0;
      retry_limit = RETRY_LIMIT_RST; highest_id = HIGHEST_ID_RST;
      errors = 0;
    endfunction

    function void push(logic k, logic [7:0] tx, logic fe, logic [3:0] v,
                       logic [7:0] id, logic st);
      engine_result_t r;
      r = '{k, tx, fe, v, id, st};
      pending_results.push_back(r);
    endfunction

    function void transmit_head();
      int unsigned base;
      if (fill == 0 || waiting) return;
      base = head * FRAME_BYTES;
      for (int i = 0; i < FRAME_BYTES; i++)
        push(KIND_TX, frames[base+i], i == FRAME_BYTES-1, V_OK, 8'd0, 1'b0);
    endfunction

    function void drop_head();
      head = (head + 1) % DEPTH;
      fill--;
    endfunction

    function void queue_byte(logic [7:0] b, logic last);
      int unsigned tail, base;
      logic [7:0] sum;
      tail = (head + fill) % DEPTH;
      base = tail * FRAME_BYTES;
      sum = 0;
      if (fill >= DEPTH) blocked = 1;
      else if (build_idx < FRAME_BYTES) frames[base+build_idx] = b;
      if (build_idx < FRAME_BYTES) build_idx++;
      if (!last) return;
      if (blocked || fill >= DEPTH) begin
        build_idx = 0; blocked = 0;
        push(KIND_VERDICT, 8'd0, 1'b1, V_QUEUE_FULL, 8'd0, 1'b0);
        return;
      end
      for (int i = build_idx; i < FRAME_BYTES; i++) frames[base+i] = PAD_BYTE;
      seq_no++;
      frames[base+1] = seq_no;
      for (int i = 0; i < FRAME_BYTES-1; i++) sum += frames[base+i];
      frames[base+FRAME_BYTES-1] = sum;
      tries[tail] = 0;
      build_idx = 0; blocked = 0;
      fill++;
      if (fill == 1) transmit_head();
    endfunction

    function void judge();
      logic [7:0] id;
      logic [3:0] v;
      logic st;
      int unsigned base, cnt, n0;
      id = rx_buf[0]; st = 0;
      if (fill == 0) begin
        push(KIND_VERDICT, 8'd0, 1'b1, V_UNSOLICITED, id, 1'b0);
        return;
      end
      base = head * FRAME_BYTES;
      if (rx_buf[FRAME_BYTES-1] != rx_sum) begin
        drop_head(); v = V_BAD_SUM;
      end else if (id[7:4] == REJECT_NIBBLE) begin
        if (waiting) v = V_REQUEUED;
        else begin
          cnt = tries[head] + 1;
          if (cnt > retry_limit) begin
            drop_head(); v = V_ABORTED;
          end else begin
            tries[head] = cnt[2:0]; waiting = 1; st = 1; v = V_RETRY;
          end
        end
      end else begin
        drop_head();
        if (id != frames[base] || id > highest_id) v = V_BAD_ID;
        else if (rx_buf[1] != frames[base+1]) v = V_BAD_SEQ;
        else v = V_OK;
      end
      push(KIND_VERDICT, 8'd0, 1'b1, v, id, st);
      n0 = pending_results.size();
      transmit_head();
      if (pending_results.size() > n0) pending_results[n0-1].frame_end = 1'b0;
    endfunction

    // note an accepted input item
    function void note_input(logic [1:0] cmd, logic [7:0] b, logic last);
      case (cmd)
        CMD_QUEUE: queue_byte(b, last);
        CMD_REPLY: begin
          if (rx_idx >= FRAME_BYTES) rx_idx = 0;
          rx_buf[rx_idx] = b;
          if (rx_idx < FRAME_BYTES-1) rx_sum += b;
          rx_idx++;
          if (rx_idx == FRAME_BYTES) begin
            rx_idx = 0;
            judge();
            rx_sum = 0;
          end
        end
        CMD_TICK: begin
          waiting = 0;
          transmit_head();
        end
        default: ;
      endcase
    endfunction

    // compare an accepted result with the oldest expectation
    function void check_result(engine_result_t got);
      engine_result_t exp_r;
      if (pending_results.size() == 0) begin
        $error("unexpected result kind=%0d verdict=%0d", got.kind, got.verdict);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.kind !== exp_r.kind) begin
        $error("kind exp %0h got %0h", exp_r.kind, got.kind); errors++;
      end
      if (got.tx_byte !== exp_r.tx_byte) begin
        $error("tx_byte exp %0h got %0h", exp_r.tx_byte, got.tx_byte); errors++;
      end
      if (got.frame_end !== exp_r.frame_end) begin
        $error("frame_end exp %0h got %0h", exp_r.frame_end, got.frame_end); errors++;
      end
      if (got.verdict !== exp_r.verdict) begin
        $error("verdict exp %0h got %0h", exp_r.verdict, got.verdict); errors++;
      end
      if (got.reply_id !== exp_r.reply_id) begin
        $error("reply_id exp %0h got %0h", exp_r.reply_id, got.reply_id); errors++;
      end
      if (got.start_timer !== exp_r.start_timer) begin
        $error("start_timer exp %0h got %0h", exp_r.start_timer, got.start_timer);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] command_i = CMD_QUEUE;
  logic [7:0] data_byte_i = 8'd0;
  logic last_byte_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic kind_o, frame_end_o, start_timer_o;
  logic [7:0] tx_byte_o, reply_id_o;
  logic [3:0] verdict_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_RETRY_LIMIT;
  logic [7:0] cfg_data_i = 8'd0;

  frame_engine_scoreboard sb = new();
  int unsigned cycle_count = 0;
  bit calm_tail = 0;      // no idling on either side near the end
  int unsigned items_sent = 0;

  always #1 clk_i = ~clk_i;

  mcu_command_frame_engine_unit #(.QUEUE_DEPTH(DEPTH)) i_dut (.*);

  // watchdog against a hung handshake
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: check accepted items, stall in random bursts
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_result('{kind_o, tx_byte_o, frame_end_o, verdict_o, reply_id_o,
                          start_timer_o});
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 16);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // send one input item, maybe after a random idle burst
  task automatic send_item(logic [1:0] cmd, logic [7:0] b, logic last);
    if (!calm_tail && $urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    in_valid_i <= 1'b1;
    command_i <= cmd;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(cmd, b, last);
    in_valid_i <= 1'b0;
    items_sent++;
    // the block is busy with the item for this cycle anyway
    @(posedge clk_i);
  endtask

  // queue a whole command of n bytes starting with the given id
  task automatic send_command(logic [7:0] id, int unsigned n);
    for (int i = 0; i < n; i++)
      send_item(CMD_QUEUE, i == 0 ? id : 8'($urandom), i == n-1);
  endtask

  // send a reply frame with the given id and seq; checksum correct unless corrupted
  task automatic send_reply(logic [7:0] id, logic [7:0] seq_b, bit bad_sum);
    logic [7:0] bytes [FRAME_BYTES];
    logic [7:0] s;
    s = 0;
    bytes[0] = id;
    bytes[1] = seq_b;
    for (int i = 2; i < FRAME_BYTES-1; i++) bytes[i] = 8'($urandom);
    for (int i = 0; i < FRAME_BYTES-1; i++) s += bytes[i];
    bytes[FRAME_BYTES-1] = bad_sum ? s ^ 8'(1 + $urandom_range(0, 254)) : s;
    for (int i = 0; i < FRAME_BYTES; i++) send_item(CMD_REPLY, bytes[i], 1'b0);
  endtask

  // reply to the current head with a chosen flavor
  task automatic answer_head();
    logic [7:0] id, sq;
    int unsigned pick;
    id = 8'($urandom); sq = 8'($urandom);
    if (sb.fill != 0) begin
      id = sb.frames[sb.head*FRAME_BYTES];
      sq = sb.frames[sb.head*FRAME_BYTES+1];
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) id = {REJECT_NIBBLE, 4'($urandom)};
    else if (pick == 1) sq = sq + 8'd1;
    else if (pick == 2) id = 8'($urandom);
    send_reply(id, sq, pick == 3);
  endtask

  // wait for all expected results and the block to settle
  task automatic drain();
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_RETRY_LIMIT) sb.retry_limit = val[2:0];
    else if (idx == REG_HIGHEST_ID) sb.highest_id = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    send_reply(8'h10, 8'h00, 0);                 // reply with nothing queued
    send_command(8'h00, 1);                      // shortest command, id 0
    send_reply(8'h00, 8'h01, 0);                 // ok
    send_command(8'hFF, 14);                     // longer than a frame
    send_item(2'd3, 8'hAA, 1'b1);                // unknown command ignored
    send_reply(8'hF3, 8'h00, 0);                 // reject: retry
    send_reply(8'hF0, 8'h00, 0);                 // reject while waiting: requeued
    send_item(CMD_TICK, 8'h55, 1'b0);            // tick resends head
    send_reply(8'hFF, 8'h02, 1);                 // bad sum drops head
    send_item(CMD_TICK, 8'h00, 1'b0);            // tick with empty queue
    drain();

    write_reg(REG_RETRY_LIMIT, 8'd0);
    write_reg(REG_HIGHEST_ID, 8'd255);
    send_command(8'hC8, 3);
    send_reply(8'hF1, 8'h00, 0);                 // aborted at limit zero
    send_command(8'hC9, 2);
    send_reply(8'hC9, 8'h00, 0);                 // bad seq
    drain();

    // fill the queue beyond depth, then answer heads until it is empty
    write_reg(REG_RETRY_LIMIT, 8'd7);
    write_reg(REG_HIGHEST_ID, 8'd0);
    for (int c = 0; c < DEPTH + 2; c++) send_command(8'($urandom), $urandom_range(1, 3));
    drain();                                     // sender pauses for all results
    while (sb.fill != 0) answer_head();
    drain();

    // random part over several register settings
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(REG_RETRY_LIMIT, phase == 0 ? 8'd7 : 8'($urandom_range(0, 7)));
      write_reg(REG_HIGHEST_ID, phase == 1 ? 8'd0 : (phase == 2 ? 8'd255 :
                8'($urandom)));
      if (phase == 3) calm_tail = 1;
      for (int t = 0; t < 14 && items_sent < 360; t++) begin
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 8) send_command(8'($urandom_range(0, 90)), $urandom_range(1, 13));
        else if (r < 16) answer_head();
        else if (r < 18) send_item(CMD_TICK, 8'($urandom), 1'($urandom));
        else if (r < 19) send_item(CMD_REPLY, 8'($urandom), 1'($urandom));
        else send_item(2'd3, 8'($urandom), 1'($urandom));
      end
      drain();
      // resync the reply framer so later phases stay well formed
      while (sb.rx_idx != 0) send_item(CMD_REPLY, 8'($urandom), 1'b0);
      send_item(CMD_TICK, 8'd0, 1'b0);
      while (sb.fill != 0) answer_head();
      drain();
    end

    drain();
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
